@@ rtl/tgap_pkg.sv @@
`timescale 1ns / 1ps
package tgap_pkg;

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_PIXELS = 2'd1;
  localparam logic [1:0] PHASE_IDLE   = 2'd2;

  localparam logic [2:0] ST_PIXEL  = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_BADSIG = 3'd2;
  localparam logic [2:0] ST_ZERO   = 3'd3;
  localparam logic [2:0] ST_DEPTH  = 3'd4;
  localparam logic [2:0] ST_TRUNC  = 3'd5;

  localparam logic [4:0] SIG_LEN  = 5'd12;
  localparam logic [4:0] POS_WLO  = 5'd12;
  localparam logic [4:0] POS_WHI  = 5'd13;
  localparam logic [4:0] POS_HLO  = 5'd14;
  localparam logic [4:0] POS_HHI  = 5'd15;
  localparam logic [4:0] POS_DEP  = 5'd16;
  localparam logic [4:0] HDR_LAST = 5'd17;

  localparam logic [7:0] DEPTH24 = 8'd24;
  localparam logic [7:0] DEPTH32 = 8'd32;

  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;
  localparam logic [QAW:0] QFULL = (QAW + 1)'(QDEPTH);

  typedef struct packed {
    logic [1:0]  cnt;
    logic [2:0]  status;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] width;
    logic [15:0] height;
    logic        alpha;
    logic        last;
  } cmd_t;

  function automatic logic [7:0] sig_byte(input logic [4:0] pos);
    sig_byte = (pos == 5'd2) ? 8'd2 : 8'd0;
  endfunction

endpackage

@@ rtl/tgap_front.sv @@
`timescale 1ns / 1ps
module tgap_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               file_start,
  input  logic               file_end,
  output logic               push,
  output tgap_pkg::cmd_t     cmd
);

  logic [1:0]  phase, phase_next;
  logic [4:0]  hpos, hpos_next;
  logic [15:0] width, width_next;
  logic [15:0] height, height_next;
  logic        four, four_next;
  logic [1:0]  pip, pip_next;
  logic [7:0]  held0, held0_next;
  logic [7:0]  held1, held1_next;
  logic [31:0] left, left_next;

  logic [1:0]  e_phase;
  logic [4:0]  e_hpos;
  logic [15:0] e_width, e_height;
  logic        e_four;
  logic [1:0]  e_pip;
  logic [7:0]  e_held0, e_held1;
  logic [31:0] e_left;
  logic        done, last;
  logic [31:0] left_dec;

  always_comb begin
    e_phase  = file_start ? tgap_pkg::PHASE_HEADER : phase;
    e_hpos   = file_start ? 5'd0 : hpos;
    e_width  = file_start ? 16'd0 : width;
    e_height = file_start ? 16'd0 : height;
    e_four   = file_start ? 1'b0 : four;
    e_pip    = file_start ? 2'd0 : pip;
    e_held0  = file_start ? 8'd0 : held0;
    e_held1  = file_start ? 8'd0 : held1;
    e_left   = file_start ? 32'd0 : left;

    phase_next  = e_phase;
    hpos_next   = e_hpos;
    width_next  = e_width;
    height_next = e_height;
    four_next   = e_four;
    pip_next    = e_pip;
    held0_next  = e_held0;
    held1_next  = e_held1;
    left_next   = e_left;
    done        = 1'b0;
    last        = 1'b0;
    left_dec    = e_left;

    cmd        = '0;
    cmd.b0     = data_byte;
    cmd.b1     = e_held1;
    cmd.b2     = e_held0;

    case (e_phase)
      tgap_pkg::PHASE_HEADER: begin
        cmd.b0 = 8'd0;
        if (e_hpos == tgap_pkg::POS_WLO) width_next[7:0] = data_byte;
        if (e_hpos == tgap_pkg::POS_WHI) width_next[15:8] = data_byte;
        if (e_hpos == tgap_pkg::POS_HLO) height_next[7:0] = data_byte;
        if (e_hpos == tgap_pkg::POS_HHI) height_next[15:8] = data_byte;
        if (e_hpos == tgap_pkg::POS_DEP) held0_next = data_byte;
        if (e_hpos < tgap_pkg::SIG_LEN && data_byte != tgap_pkg::sig_byte(e_hpos)) begin
          width_next  = e_width;
          height_next = e_height;
          phase_next  = tgap_pkg::PHASE_IDLE;
          cmd.cnt     = 2'd1;
          cmd.status  = tgap_pkg::ST_BADSIG;
        end else if (e_hpos < tgap_pkg::HDR_LAST) begin
          hpos_next = e_hpos + 5'd1;
          if (file_end) begin
            phase_next = tgap_pkg::PHASE_IDLE;
            cmd.cnt    = 2'd1;
            cmd.status = tgap_pkg::ST_TRUNC;
          end
        end else begin
          hpos_next = 5'd0;
          cmd.cnt   = 2'd1;
          if (e_width == 16'd0 || e_height == 16'd0) begin
            phase_next = tgap_pkg::PHASE_IDLE;
            cmd.status = tgap_pkg::ST_ZERO;
          end else if (e_held0 != tgap_pkg::DEPTH24 && e_held0 != tgap_pkg::DEPTH32) begin
            phase_next = tgap_pkg::PHASE_IDLE;
            cmd.status = tgap_pkg::ST_DEPTH;
          end else begin
            four_next  = (e_held0 == tgap_pkg::DEPTH32);
            left_next  = {16'd0, e_width} * {16'd0, e_height};
            pip_next   = 2'd0;
            held0_next = 8'd0;
            if (file_end) begin
              phase_next = tgap_pkg::PHASE_IDLE;
              cmd.status = tgap_pkg::ST_TRUNC;
            end else begin
              phase_next = tgap_pkg::PHASE_PIXELS;
              cmd.status = tgap_pkg::ST_ACCEPT;
            end
          end
        end
        cmd.width  = width_next;
        cmd.height = height_next;
        cmd.alpha  = four_next;
      end
      tgap_pkg::PHASE_PIXELS: begin
        case (e_pip)
          2'd0: begin
            held0_next = data_byte;
            pip_next   = 2'd1;
          end
          2'd1: begin
            held1_next = data_byte;
            pip_next   = 2'd2;
          end
          2'd2: begin
            pip_next = e_four ? 2'd3 : 2'd0;
            done     = !e_four;
          end
          default: begin
            pip_next = 2'd0;
            done     = 1'b1;
          end
        endcase
        if (done && e_left != 32'd0) left_dec = e_left - 32'd1;
        left_next  = left_dec;
        last       = done && left_dec == 32'd0;
        cmd.width  = e_width;
        cmd.height = e_height;
        cmd.alpha  = e_four;
        if (file_end && !last) begin
          phase_next = tgap_pkg::PHASE_IDLE;
          cmd.cnt    = 2'd1;
          cmd.status = tgap_pkg::ST_TRUNC;
          cmd.b0     = 8'd0;
        end else begin
          if (e_pip == 2'd2) begin
            cmd.cnt  = 2'd3;
            cmd.last = !e_four && last;
          end else if (e_pip == 2'd3) begin
            cmd.cnt  = 2'd1;
            cmd.last = last;
          end
          cmd.status = tgap_pkg::ST_PIXEL;
          if (last) phase_next = tgap_pkg::PHASE_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign push = accept && cmd.cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= tgap_pkg::PHASE_HEADER;
      hpos   <= 5'd0;
      width  <= 16'd0;
      height <= 16'd0;
      four   <= 1'b0;
      pip    <= 2'd0;
      held0  <= 8'd0;
      held1  <= 8'd0;
      left   <= 32'd0;
    end else if (accept) begin
      phase  <= phase_next;
      hpos   <= hpos_next;
      width  <= width_next;
      height <= height_next;
      four   <= four_next;
      pip    <= pip_next;
      held0  <= held0_next;
      held1  <= held1_next;
      left   <= left_next;
    end
  end

endmodule

@@ rtl/tgap_fifo.sv @@
`timescale 1ns / 1ps
module tgap_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tgap_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output tgap_pkg::cmd_t rd_cmd,
  output logic           full,
  output logic           empty
);

  tgap_pkg::cmd_t entries [tgap_pkg::QDEPTH];
  logic [tgap_pkg::QAW-1:0] wr_ptr;
  logic [tgap_pkg::QAW-1:0] rd_ptr;
  logic [tgap_pkg::QAW:0]   count;

  assign full   = count == tgap_pkg::QFULL;
  assign empty  = count == '0;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/tgap_back.sv @@
`timescale 1ns / 1ps
module tgap_back (
  input  logic           clk,
  input  logic           rst,
  input  tgap_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     pixel_byte,
  output logic [2:0]     status,
  output logic [15:0]    image_width,
  output logic [15:0]    image_height,
  output logic           has_alpha,
  output logic           last_of_image
);

  logic [1:0] idx;
  logic       final_sub;

  assign final_sub = idx == head.cnt - 2'd1;
  assign out_valid = !empty;
  assign pop       = out_valid && out_ready && final_sub;

  always_comb begin
    case (idx)
      2'd0:    pixel_byte = head.b0;
      2'd1:    pixel_byte = head.b1;
      default: pixel_byte = head.b2;
    endcase
  end

  assign status        = head.status;
  assign image_width   = head.width;
  assign image_height  = head.height;
  assign has_alpha     = head.alpha;
  assign last_of_image = final_sub && head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= final_sub ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

@@ rtl/tga_uncompressed_stream_parser.sv @@
`timescale 1ns / 1ps
// Results enter the 4-entry queue as their bytes are accepted. Bytes are taken
// one per cycle while the queue is not full; results leave one per cycle while
// out_ready is high, and a three-byte pixel is one entry giving three results.
// Reset (rst, synchronous): parser returns to header phase, queue empties.
module tga_uncompressed_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  input  logic        file_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_byte,
  output logic [2:0]  status,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        has_alpha,
  output logic        last_of_image
);

  tgap_pkg::cmd_t wr_cmd;
  tgap_pkg::cmd_t head;
  logic           push, pop, full, empty, accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  tgap_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .file_start (file_start),
    .file_end   (file_end),
    .push       (push),
    .cmd        (wr_cmd)
  );

  tgap_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (head),
    .full   (full),
    .empty  (empty)
  );

  tgap_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_byte    (pixel_byte),
    .status        (status),
    .image_width   (image_width),
    .image_height  (image_height),
    .has_alpha     (has_alpha),
    .last_of_image (last_of_image)
  );

endmodule
